// ===== hw/rtl/clar_pkg.sv =====
package clar_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_LISTED    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_REMOVE,
    OP_EMPTY,
    OP_LIST_EMIT
  } dp_op_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_LIST
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic list_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/compacting_list_append_remove_unit.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o   | in_kind_i, in_value_i
// out     | output    | out_valid_o / out_stall_i | out_status_o, out_entry_o, out_last_o
//
// add and remove each give one result; the compare of the value against every stored
// cell and the compacting shift happen in the cycle the command is taken
// list gives one result per cycle per stored entry, unless the output stalls, through the single output register
// reset clears the fill count and output valid; stored values are undefined until written
// input stalls while the output register holds a result not yet taken, and for a whole list
module compacting_list_append_remove_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_kind_i,
  input  logic signed [31:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic signed [31:0] out_entry_o,
  output logic               out_last_o
);
  import clar_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_kind_i  (in_kind_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clar_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_value_i   (in_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_status_o (out_status_o),
    .out_entry_o  (out_entry_o),
    .out_last_o   (out_last_o)
  );

  // a command never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op != OP_NONE) |-> stat.out_free)
    else $error("datapath loaded while output register busy");

  // a list emit that is not the last keeps the input stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_LIST_EMIT && !stat.list_last) |=> in_stall_o)
    else $error("input open in the middle of a list");

  // only listed entries can be non-final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != STAT_LISTED) |-> (out_last_o && out_entry_o == '0))
    else $error("status result not marked last or entry not zero");

endmodule

// ===== hw/rtl/clar_ctrl.sv =====
module clar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_kind_i,
  input  clar_pkg::dp_stat_t stat_i,
  output clar_pkg::dp_cmd_t  cmd_o
);
  import clar_pkg::*;

  ctrl_state_e state_q, state_d;
  kind_e       kind;

  assign kind = kind_e'(in_kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      CTRL_IDLE: begin
        in_stall_o = !stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          unique case (kind)
            KIND_ADD:    cmd_o.op = OP_ADD;
            KIND_REMOVE: cmd_o.op = OP_REMOVE;
            KIND_LIST: begin
              if (stat_i.empty) begin
                cmd_o.op = OP_EMPTY;
              end else begin
                cmd_o.op = OP_LIST_EMIT;
                if (!stat_i.list_last) begin
                  state_d = CTRL_LIST;
                end
              end
            end
            KIND_UNUSED: cmd_o.op = OP_NONE;
            default:     cmd_o.op = OP_NONE;
          endcase
        end
      end
      CTRL_LIST: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_LIST_EMIT;
          if (stat_i.list_last) begin
            state_d = CTRL_IDLE;
          end
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/clar_dp.sv =====
module clar_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clar_pkg::dp_cmd_t   cmd_i,
  output clar_pkg::dp_stat_t  stat_o,
  input  logic signed [31:0]  in_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          out_status_o,
  output logic signed [31:0]  out_entry_o,
  output logic                out_last_o
);
  import clar_pkg::*;

  logic [DataW-1:0]    cells_q [Capacity];
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [DataW-1:0]    out_entry_q, out_entry_d;
  logic                out_last_q, out_last_d;

  logic                full, empty, list_last, out_free, found, add_ok, rm_ok;
  logic [Capacity-1:0] hit, first, shift_en, cell_we;

  assign full      = (count_q == CntW'(Capacity));
  assign empty     = (count_q == '0);
  assign list_last = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      hit[i] = (CntW'(i) < count_q) && (cells_q[i] == in_value_i);
    end
  end

  assign first    = hit & (~hit + Capacity'(1));
  assign shift_en = ~(first - Capacity'(1));
  assign found    = |hit;
  assign add_ok   = (cmd_i.op == OP_ADD) && !full;
  assign rm_ok    = (cmd_i.op == OP_REMOVE) && found;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      cell_we[i] = add_ok && (count_q == CntW'(i));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Capacity; i++) begin
      if (cell_we[i]) begin
        cells_q[i] <= in_value_i;
      end else if (rm_ok && shift_en[i] && (i < Capacity - 1)) begin
        cells_q[i] <= cells_q[(i < Capacity - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_ADD: begin
        out_valid_d  = 1'b1;
        out_status_d = full ? STAT_FULL : STAT_ADDED;
        out_entry_d  = '0;
        out_last_d   = 1'b1;
        if (add_ok) begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        out_valid_d  = 1'b1;
        out_entry_d  = '0;
        out_last_d   = 1'b1;
        if (empty) begin
          out_status_d = STAT_EMPTY;
        end else if (found) begin
          out_status_d = STAT_REMOVED;
          count_d      = count_q - CntW'(1);
        end else begin
          out_status_d = STAT_NOT_FOUND;
        end
      end
      OP_EMPTY: begin
        out_valid_d  = 1'b1;
        out_status_d = STAT_EMPTY;
        out_entry_d  = '0;
        out_last_d   = 1'b1;
      end
      OP_LIST_EMIT: begin
        out_valid_d  = 1'b1;
        out_status_d = STAT_LISTED;
        out_entry_d  = cells_q[idx_q];
        out_last_d   = list_last;
        idx_d        = list_last ? '0 : idx_q + IdxW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_last_q   <= out_last_d;
  end

  assign stat_o.out_free  = out_free;
  assign stat_o.empty     = empty;
  assign stat_o.list_last = list_last;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_entry_o  = out_entry_q;
  assign out_last_o   = out_last_q;

endmodule
